[hw/rtl/crbm_pkg.sv]
// crbm_pkg: shared types and constants of the cpu rate and busy meter
// holds the input and result beat structs, the sequencer and job enums
// no dependencies
package crbm_pkg;

  localparam int CPU_IDX_W = 6;
  localparam int INST_W    = 40;
  localparam int SIO_W     = 32;
  localparam int TOD_W     = 64;
  localparam int RATE_W    = 64;
  localparam int BUSY_W    = 7;
  localparam int TPS_W     = 32;
  localparam int PROD_W    = TOD_W + TPS_W;

  localparam int                NUM_CPUS_DEF         = 64;
  localparam logic [TPS_W-1:0]  TICKS_PER_SECOND_DEF = 32'd4096000000;

  // busy share is scaled by one hundred and capped there
  localparam logic [BUSY_W-1:0] BUSY_SCALE = 7'd100;
  localparam int                BUSY_MUL_BITS = BUSY_W;

  typedef struct packed {
    logic [CPU_IDX_W-1:0] cpu_index;
    logic                 cpu_stopped;
    logic [INST_W-1:0]    inst_count;
    logic [SIO_W-1:0]     sio_count;
    logic [TOD_W-1:0]     wait_ticks;
    logic [TOD_W-1:0]     wait_start_tod;
    logic [TOD_W-1:0]     period_start_tod;
    logic [TOD_W-1:0]     now_tod;
    logic                 last_cpu;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] inst_rate;
    logic [RATE_W-1:0] sio_rate;
    logic [BUSY_W-1:0] busy_percent;
    logic [RATE_W-1:0] sum_inst_rate;
    logic [RATE_W-1:0] sum_sio_rate;
    logic [TOD_W-1:0]  wait_start_out;
    logic [RATE_W-1:0] lifetime_instructions;
    logic [RATE_W-1:0] lifetime_sios;
    logic [RATE_W-1:0] lifetime_wait;
  } out_item_t;

  // one row of the per-cpu lifetime store
  typedef struct packed {
    logic [RATE_W-1:0] inst;
    logic [RATE_W-1:0] sio;
    logic [RATE_W-1:0] wait_sum;
  } life_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_WAIT,
    ST_LOAD,
    ST_MUL,
    ST_ROUND,
    ST_CHK,
    ST_DIV,
    ST_STORE,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    JOB_INST,
    JOB_SIO,
    JOB_BUSY
  } job_e;

endpackage

[hw/rtl/cpu_rate_and_busy_meter.sv]
// cpu_rate_and_busy_meter: top level, sequencer, bit-serial multiply/divide and lifetime store
// depends on crbm_pkg
//
// Each input beat closes one measurement period of one cpu and yields one result beat:
// rounded instruction and i/o start rates per second, busy percent, the running all-cpu
// rate sums and the cpu's lifetime totals. For a running cpu, three quotients share one
// shift-add multiplier and one restoring divider that retires one quotient bit per cycle.
// A stopped cpu, or a zero-length period, skips the unit. One beat is worked on at a
// time; a new beat is taken while the previous result still sits in the output register.
// The lifetime store is one row per cpu with a valid flop per row, so it is ready right
// after reset with no clearing pass.
module cpu_rate_and_busy_meter #(
  parameter int                             NUM_CPUS         = crbm_pkg::NUM_CPUS_DEF,
  parameter logic [crbm_pkg::TPS_W-1:0]     TICKS_PER_SECOND = crbm_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crbm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crbm_pkg::out_item_t out_data_o
);
  import crbm_pkg::*;

  localparam int AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  state_e state_q, state_d;
  job_e   job_q;

  in_item_t item_q;
  logic [TOD_W-1:0]  period_q;
  logic [TOD_W-1:0]  wsum_q;
  logic              running_q;
  logic [TOD_W-1:0]  a_q;
  logic [TPS_W-1:0]  b_q;
  logic [PROD_W-1:0] acc_q;
  logic [TOD_W-1:0]  rem_q;
  logic [5:0]        cnt_q;
  logic [RATE_W-1:0] irate_q, srate_q;
  logic [BUSY_W-1:0] busy_q;
  logic [RATE_W-1:0] sum_inst_q, sum_sio_q;
  life_t             life_q;
  out_item_t         out_q;
  logic              out_valid_q;

  life_t             life_mem [NUM_CPUS];
  life_t             life_rd_q;
  logic [NUM_CPUS-1:0] row_vld_q;

  logic              in_accept, out_load, mem_we;
  logic              row_ok, skip, ovf, take;
  logic [AW-1:0]     addr;
  life_t             life_cur, life_new;
  logic [TOD_W:0]    rem_sh, rem_sub;
  logic [RATE_W-1:0] res;

  function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? '1 : s[63:0];
  endfunction

  assign addr     = item_q.cpu_index[AW-1:0];
  assign row_ok   = ({1'b0, item_q.cpu_index} < (CPU_IDX_W + 1)'(NUM_CPUS));
  assign life_cur = row_vld_q[addr] ? life_rd_q : '0;
  assign life_new.inst     = life_cur.inst + RATE_W'(item_q.inst_count);
  assign life_new.sio      = life_cur.sio + RATE_W'(item_q.sio_count);
  assign life_new.wait_sum = life_cur.wait_sum + item_q.wait_ticks;

  // a job is skipped on a zero period, and busy also when the wait fills the period
  assign skip = (period_q == '0) || ((job_q == JOB_BUSY) && !(wsum_q < period_q));
  assign ovf  = ({(TOD_W - TPS_W)'(0), acc_q[PROD_W-1:TOD_W]} >= period_q);

  // restoring divide step, dividend bits shift out of the low half of acc
  assign rem_sh  = {rem_q, acc_q[TOD_W-1]};
  assign take    = (rem_sh >= {1'b0, period_q});
  assign rem_sub = rem_sh - {1'b0, period_q};
  assign res     = acc_q[RATE_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PREP;
      ST_PREP:   state_d = ST_WAIT;
      ST_WAIT:   state_d = item_q.cpu_stopped ? ST_UPDATE : ST_LOAD;
      ST_LOAD:   state_d = skip ? ST_STORE : ST_MUL;
      ST_MUL:    if (cnt_q == '0) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_CHK;
      ST_CHK:    state_d = ovf ? ST_STORE : ST_DIV;
      ST_DIV:    if (cnt_q == '0) state_d = ST_STORE;
      ST_STORE:  state_d = (job_q == JOB_BUSY) ? ST_UPDATE : ST_LOAD;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
    mem_we     = (state_q == ST_UPDATE) && !item_q.cpu_stopped && row_ok;
  end

  assign in_accept = in_valid_i && in_ready_o;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_INST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
      sum_inst_q  <= '0;
      sum_sio_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          job_q <= JOB_INST;
        end
        ST_LOAD: begin
          cnt_q <= (job_q == JOB_BUSY) ? 6'(BUSY_MUL_BITS - 1) : 6'(TPS_W - 1);
        end
        ST_MUL, ST_DIV: begin
          cnt_q <= cnt_q - 6'd1;
        end
        ST_CHK: begin
          cnt_q <= 6'(TOD_W - 1);
        end
        ST_STORE: begin
          job_q <= (job_q == JOB_INST) ? JOB_SIO : JOB_BUSY;
        end
        ST_UPDATE: begin
          if (!item_q.cpu_stopped) begin
            sum_inst_q <= sat_add(sum_inst_q, irate_q);
            sum_sio_q  <= sat_add(sum_sio_q, srate_q);
          end
          if (mem_we) row_vld_q[addr] <= 1'b1;
        end
        ST_OUT: begin
          // sums clear after the final cpu's beat has been taken into the output register
          if (out_load && item_q.last_cpu) begin
            sum_inst_q <= '0;
            sum_sio_q  <= '0;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q  <= in_data_i;
      irate_q <= '0;
      srate_q <= '0;
      busy_q  <= '0;
    end
    case (state_q)
      ST_PREP: begin
        period_q  <= item_q.now_tod - item_q.period_start_tod;
        wsum_q    <= item_q.now_tod - item_q.wait_start_tod;
        running_q <= (item_q.wait_start_tod >= item_q.period_start_tod);
      end
      ST_WAIT: begin
        wsum_q <= running_q ? sat_add(item_q.wait_ticks, wsum_q) : item_q.wait_ticks;
      end
      ST_LOAD: begin
        acc_q <= '0;
        case (job_q)
          JOB_INST: begin
            a_q <= TOD_W'(item_q.inst_count);
            b_q <= TICKS_PER_SECOND;
          end
          JOB_SIO: begin
            a_q <= TOD_W'(item_q.sio_count);
            b_q <= TICKS_PER_SECOND;
          end
          default: begin
            a_q <= period_q - wsum_q;
            b_q <= {BUSY_SCALE, (TPS_W - BUSY_W)'(0)};
          end
        endcase
      end
      ST_MUL: begin
        acc_q <= {acc_q[PROD_W-2:0], 1'b0} + (b_q[TPS_W-1] ? PROD_W'(a_q) : '0);
        b_q   <= {b_q[TPS_W-2:0], 1'b0};
      end
      ST_ROUND: begin
        acc_q <= acc_q + PROD_W'(period_q[TOD_W-1:1]);
      end
      ST_CHK: begin
        if (ovf) begin
          acc_q[RATE_W-1:0] <= '1;
        end else begin
          rem_q <= TOD_W'(acc_q[PROD_W-1:TOD_W]);
        end
      end
      ST_DIV: begin
        rem_q             <= take ? rem_sub[TOD_W-1:0] : rem_sh[TOD_W-1:0];
        acc_q[TOD_W-1:0]  <= {acc_q[TOD_W-2:0], take};
      end
      ST_STORE: begin
        case (job_q)
          JOB_INST: irate_q <= res;
          JOB_SIO:  srate_q <= res;
          default:  busy_q  <= (res > RATE_W'(BUSY_SCALE)) ? BUSY_SCALE : res[BUSY_W-1:0];
        endcase
      end
      ST_UPDATE: begin
        if (!row_ok) begin
          life_q <= '0;
        end else if (item_q.cpu_stopped) begin
          life_q <= life_cur;
        end else begin
          life_q <= life_new;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.inst_rate             <= irate_q;
      out_q.sio_rate              <= srate_q;
      out_q.busy_percent          <= busy_q;
      out_q.sum_inst_rate         <= sum_inst_q;
      out_q.sum_sio_rate          <= sum_sio_q;
      out_q.wait_start_out        <= (running_q && !item_q.cpu_stopped) ?
                                     item_q.now_tod : item_q.wait_start_tod;
      out_q.lifetime_instructions <= life_q.inst;
      out_q.lifetime_sios         <= life_q.sio;
      out_q.lifetime_wait         <= life_q.wait_sum;
    end
  end

  // lifetime store, registered read of the current beat's row
  always_ff @(posedge clk_i) begin
    if (mem_we) life_mem[addr] <= life_new;
    life_rd_q <= life_mem[addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // busy share never leaves its range
  a_busy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.busy_percent <= BUSY_SCALE))
    else $error("busy percent above cap");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < period_q))
    else $error("divider remainder out of range");

  // a stopped cpu gives no rate
  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && item_q.cpu_stopped) |-> (irate_q == '0 && srate_q == '0))
    else $error("stopped cpu produced a rate");

  // the final cpu's beat leaves cleared sums behind
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_q.last_cpu) |=> (sum_inst_q == '0 && sum_sio_q == '0))
    else $error("rate sums not cleared after final cpu");

endmodule

[verif/cpu_rate_and_busy_meter_tb.sv]
// cpu_rate_and_busy_meter_tb: self-checking testbench of the cpu rate and busy meter
// directed period closes, then random sweeps and noise, checked against an in-bench predictor
// depends on crbm_pkg and cpu_rate_and_busy_meter
`timescale 1ns / 1ps

module cpu_rate_and_busy_meter_tb;
  import crbm_pkg::*;

  localparam logic [63:0] TPS        = 64'(TICKS_PER_SECOND_DEF);
  localparam logic [39:0] INST_MAX   = '1;
  localparam logic [31:0] SIO_MAX    = '1;
  localparam logic [63:0] ALL_ONES   = '1;
  localparam logic [63:0] P          = 64'h0000_1234_5678_0000;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;

  // predictor state: per-cpu lifetime totals and the all-cpu rate sums
  logic [63:0] life_inst [64];
  logic [63:0] life_sio  [64];
  logic [63:0] life_idle [64];
  logic [63:0] inst_rate_sum;
  logic [63:0] sio_rate_sum;

  out_item_t   pending_readings[$];
  int unsigned beats_sent;
  int unsigned mismatch_count;
  bit          idling_on = 1'b1;
  int unsigned stall_left;

  cpu_rate_and_busy_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  // (num * mult + den/2) / den at full width, all ones when it does not fit, zero when den is zero
  function automatic logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] mult,
                                                  logic [63:0] den);
    logic [127:0] acc;
    logic [127:0] quo;
    if (den == 64'd0) return 64'd0;
    acc = {64'd0, num} * {64'd0, mult} + {64'd0, den >> 1};
    quo = acc / {64'd0, den};
    return (quo[127:64] != 64'd0) ? ALL_ONES : quo[63:0];
  endfunction

  function automatic out_item_t close_period(in_item_t b);
    out_item_t   r;
    logic [63:0] span;
    logic [63:0] idle_sum;
    logic [63:0] busy_full;
    bit          known_cpu;
    r         = '0;
    span      = b.now_tod - b.period_start_tod;
    known_cpu = int'(b.cpu_index) < NUM_CPUS_DEF;
    r.wait_start_out = b.wait_start_tod;
    if (!b.cpu_stopped) begin
      r.inst_rate   = scaled_quotient(64'(b.inst_count), TPS, span);
      r.sio_rate    = scaled_quotient(64'(b.sio_count), TPS, span);
      inst_rate_sum = clamp_add(inst_rate_sum, r.inst_rate);
      sio_rate_sum  = clamp_add(sio_rate_sum, r.sio_rate);
      if (known_cpu) begin
        life_inst[b.cpu_index] += 64'(b.inst_count);
        life_sio[b.cpu_index]  += 64'(b.sio_count);
        life_idle[b.cpu_index] += b.wait_ticks;
      end
      idle_sum = b.wait_ticks;
      // a wait still open at period close counts up to now
      if (b.wait_start_tod >= b.period_start_tod) begin
        idle_sum         = clamp_add(idle_sum, b.now_tod - b.wait_start_tod);
        r.wait_start_out = b.now_tod;
      end
      if (idle_sum < span) begin
        busy_full = scaled_quotient(span - idle_sum, 64'(BUSY_SCALE), span);
        if (busy_full > 64'(BUSY_SCALE)) busy_full = 64'(BUSY_SCALE);
        r.busy_percent = busy_full[BUSY_W-1:0];
      end
    end
    r.sum_inst_rate = inst_rate_sum;
    r.sum_sio_rate  = sio_rate_sum;
    if (known_cpu) begin
      r.lifetime_instructions = life_inst[b.cpu_index];
      r.lifetime_sios         = life_sio[b.cpu_index];
      r.lifetime_wait         = life_idle[b.cpu_index];
    end
    if (b.last_cpu) begin
      inst_rate_sum = '0;
      sio_rate_sum  = '0;
    end
    return r;
  endfunction

  function automatic in_item_t period_close(logic [5:0] idx, bit stopped, logic [39:0] inst,
                                            logic [31:0] sio, logic [63:0] wticks,
                                            logic [63:0] wstart, logic [63:0] pstart,
                                            logic [63:0] now, bit last);
    in_item_t b;
    b.cpu_index        = idx;
    b.cpu_stopped      = stopped;
    b.inst_count       = inst;
    b.sio_count        = sio;
    b.wait_ticks       = wticks;
    b.wait_start_tod   = wstart;
    b.period_start_tod = pstart;
    b.now_tod          = now;
    b.last_cpu         = last;
    return b;
  endfunction

  // plausible period close with random content, mostly about one second long
  function automatic in_item_t random_close(logic [5:0] idx, bit last);
    in_item_t    b;
    logic [63:0] span;
    b.cpu_index   = idx;
    b.last_cpu    = last;
    b.cpu_stopped = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 9))
      0: span = 64'($urandom_range(1, 5000));
      1: span = rand64() >> $urandom_range(0, 40);
      default: span = TPS - 64'd409600000 + 64'($urandom_range(0, 819200000));
    endcase
    b.period_start_tod = rand64();
    b.now_tod          = b.period_start_tod + span;
    b.inst_count = ($urandom_range(0, 15) == 0) ? INST_MAX
                                                 : 40'(rand64() >> $urandom_range(0, 39));
    b.sio_count  = $urandom >> $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0: b.wait_ticks = 64'd0;
      1: b.wait_ticks = rand64();
      default: b.wait_ticks = span >> $urandom_range(1, 8);
    endcase
    if ($urandom_range(0, 1) == 1)
      b.wait_start_tod = b.period_start_tod + (span >> $urandom_range(0, 12));
    else
      b.wait_start_tod = b.period_start_tod - 64'd1 - (rand64() >> $urandom_range(8, 63));
    return b;
  endfunction

  function automatic in_item_t noise_close();
    in_item_t b;
    b = period_close(6'($urandom), 1'($urandom), 40'(rand64()), $urandom, rand64(),
                     rand64(), rand64(), rand64(), $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) b.now_tod = b.period_start_tod;
    return b;
  endfunction

  task automatic send_item(input in_item_t beat);
    if (idling_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_readings.push_back(close_period(beat));
    beats_sent++;
  endtask

  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_rate_corners();
    send_item(period_close(6'd0, 0, INST_MAX, SIO_MAX, 64'd0, P - 1, P, P + TPS, 0));
    // half a beat per second rounds up
    send_item(period_close(6'd1, 0, 40'd1, 32'd1, 64'd0, P - 1, P, P + 2 * TPS, 0));
    // one-tick periods overflow the instruction rates and the instruction sum
    send_item(period_close(6'd2, 0, INST_MAX, 32'd0, 64'd0, P - 1, P, P + 1, 0));
    send_item(period_close(6'd3, 0, INST_MAX, SIO_MAX, 64'd0, P - 1, P, P + 1, 1));
    send_item(period_close(6'd4, 0, 40'd1000, 32'd7, 64'd5, P, P, P, 0));
    // period wraps through zero
    send_item(period_close(6'd5, 0, 40'd12345, 32'd67, 64'd0, 64'd10,
                           64'hFFFF_FFFF_FFFF_FF00, TPS - 64'h100, 0));
    send_item(period_close(6'd6, 0, INST_MAX, SIO_MAX, ALL_ONES, ALL_ONES, 64'd0,
                           ALL_ONES, 1));
  endtask

  task automatic test_wait_and_busy();
    send_item(period_close(6'd7, 0, 40'd5000, 32'd3, TPS / 4, P + TPS / 2, P, P + TPS, 0));
    send_item(period_close(6'd8, 0, 40'd1, 32'd1, ALL_ONES, P, P, P + TPS, 0));
    send_item(period_close(6'd9, 0, 40'd1, 32'd1, TPS, P - 5, P, P + TPS, 0));
    send_item(period_close(6'd9, 0, 40'd1, 32'd1, TPS / 200, P - 5, P, P + TPS, 0));
    // open wait that started after now wraps, so busy reads zero
    send_item(period_close(6'd10, 0, 40'd1, 32'd1, 64'd0, P + 2 * TPS, P, P + TPS, 1));
  endtask

  task automatic test_stopped_and_lifetime();
    send_item(period_close(6'd63, 1, INST_MAX, SIO_MAX, ALL_ONES, P, P, P + TPS, 0));
    // two big waits on one cpu wrap its lifetime total
    send_item(period_close(6'd63, 0, INST_MAX, SIO_MAX, 64'hFFFF_FFFF_FFFF_FFF0, 64'd0, P,
                           P + TPS, 0));
    send_item(period_close(6'd63, 0, INST_MAX, SIO_MAX, 64'hFFFF_FFFF_FFFF_FFF0, 64'd0, P,
                           P + TPS, 0));
    send_item(period_close(6'd11, 1, 40'd0, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1));
  endtask

  task automatic run_sweeps(input int unsigned target, input bit vary_idling);
    int unsigned n;
    logic [5:0]  base;
    while (beats_sent < target) begin
      if (vary_idling) idling_on = ($urandom_range(0, 3) != 0);
      n    = ($urandom_range(0, 15) == 0) ? 64 : $urandom_range(1, 8);
      base = 6'($urandom);
      for (int unsigned k = 0; k < n; k++)
        send_item(random_close(6'(base + k), k == n - 1));
    end
  endtask

  task automatic test_random_sweeps();
    run_sweeps(1300, 1'b1);
  endtask

  task automatic test_random_noise();
    idling_on = 1'b1;
    while (beats_sent < 1500) send_item(noise_close());
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    run_sweeps(1650, 1'b0);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : reading_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("inst_rate", want.inst_rate, out_data_o.inst_rate);
        check_field("sio_rate", want.sio_rate, out_data_o.sio_rate);
        check_field("busy_percent", 64'(want.busy_percent), 64'(out_data_o.busy_percent));
        check_field("sum_inst_rate", want.sum_inst_rate, out_data_o.sum_inst_rate);
        check_field("sum_sio_rate", want.sum_sio_rate, out_data_o.sum_sio_rate);
        check_field("wait_start_out", want.wait_start_out, out_data_o.wait_start_out);
        check_field("lifetime_instructions", want.lifetime_instructions,
                    out_data_o.lifetime_instructions);
        check_field("lifetime_sios", want.lifetime_sios, out_data_o.lifetime_sios);
        check_field("lifetime_wait", want.lifetime_wait, out_data_o.lifetime_wait);
      end
    end
    // receiver stalls come in short bursts
    if (!idling_on) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    inst_rate_sum = '0;
    sio_rate_sum  = '0;
    for (int i = 0; i < 64; i++) begin
      life_inst[i] = '0;
      life_sio[i]  = '0;
      life_idle[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_rate_corners();
    test_wait_and_busy();
    test_stopped_and_lifetime();
    test_random_sweeps();
    test_random_noise();
    test_steady_stream();
    drain_readings();
    repeat (400) @(posedge clk_i);
    if (mismatch_count == 0 && pending_readings.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
